@@ rtl/sfr_pkg.sv @@
// Shared constants, register codes and inter-module structs for the serial frame receiver.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package sfr_pkg;

	// Frame geometry: header, DATA_LEN-1 payload bytes, checksum, footer.
	localparam int DATA_LEN = 8;
	localparam int PAY_LEN  = DATA_LEN - 1;
	localparam int CNT_W    = $clog2(DATA_LEN);

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 6;
	localparam int TICK_W = 16;
	localparam int CFG_DW = 16;
	localparam int CFG_AW = 2;

	typedef enum logic [CFG_AW-1:0] {
		CFG_HEADER,
		CFG_FOOTER,
		CFG_TIMEOUT,
		CFG_RETRY
	} cfg_idx_t;

	localparam logic ST_DATA    = 1'b0;
	localparam logic ST_GIVE_UP = 1'b1;

	typedef struct packed {
		logic give_up;
		logic bank;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

	typedef struct packed {
		logic              en;
		logic              bank;
		logic [CNT_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} store_wr_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} done_t;

endpackage

@@ rtl/sfr_cmd_fifo.sv @@
// Two-entry command queue between the front-end frame parser and the result streamer.
// Depends on sfr_pkg for the command structs.
`timescale 1ns / 1ps

module sfr_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  sfr_pkg::push_t push_in,
	input  logic          rd,
	output logic          fifo_full,
	output logic          fifo_empty,
	output sfr_pkg::cmd_t head
);
	import sfr_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign fifo_full  = (count_q == 2'd2);
	assign fifo_empty = (count_q == 2'd0);
	assign head       = slot_q[rd_ptr_q];
	assign do_wr      = push_in.valid && !fifo_full;
	assign do_rd      = rd && !fifo_empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= push_in.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/sfr_front.sv @@
// Front end: configuration registers, tick timeout, frame parsing and failure counting.
// Writes payload bytes into the back end's two-bank store and queues stream or give-up commands.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfr_pkg::CFG_AW-1:0]     cfg_index,
	input  logic [sfr_pkg::CFG_DW-1:0]     cfg_wdata,
	input  logic                           push,
	input  logic                           action,
	input  logic [sfr_pkg::BYTE_W-1:0]     rx_byte,
	input  logic                           fifo_full,
	input  sfr_pkg::done_t                 done,
	output logic                           full,
	output sfr_pkg::push_t                 cmd_push,
	output sfr_pkg::store_wr_t             store_wr
);
	import sfr_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_BODY,
		PH_FOOT
	} phase_t;

	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] footer_q;
	logic [TICK_W-1:0] timeout_q;
	logic [BYTE_W-1:0] retry_q;

	phase_t            phase_q,   phase_d;
	logic [CNT_W-1:0]  cnt_q,     cnt_d;
	logic [BYTE_W-1:0] sum_q,     sum_d;
	logic [BYTE_W-1:0] fail_q,    fail_d;
	logic [TICK_W-1:0] idle_q,    idle_d;
	logic              bank_q,    bank_d;
	logic [1:0]        busy_q;
	logic [1:0]        busy_set;
	logic [1:0]        busy_clr;

	logic              accept;
	logic              have_byte;
	logic [BYTE_W-1:0] b;
	logic              fail;
	logic [BYTE_W-1:0] fail_inc;

	// A bank stays locked from the queued stream command until its last byte leaves.
	assign full      = fifo_full || busy_q[bank_q];
	assign accept    = push && !full;
	assign have_byte = accept && (!action || (idle_q >= timeout_q));
	assign b         = action ? '0 : rx_byte;
	assign fail_inc  = fail_q + 8'd1;

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		sum_d    = sum_q;
		fail_d   = fail_q;
		idle_d   = idle_q;
		bank_d   = bank_q;
		busy_set = 2'b00;
		fail     = 1'b0;
		cmd_push = '0;
		store_wr = '0;
		store_wr.bank = bank_q;
		store_wr.addr = cnt_q;
		store_wr.data = b;

		if (accept) begin
			if (!action || (idle_q >= timeout_q)) begin
				idle_d = '0;
			end else begin
				idle_d = idle_q + 16'd1;
			end
		end

		if (have_byte) begin
			unique case (phase_q)
				PH_BODY: begin
					if (cnt_q < CNT_W'(PAY_LEN)) begin
						store_wr.en = 1'b1;
						sum_d       = sum_q + b;
						cnt_d       = cnt_q + 1'b1;
					end else begin
						cnt_d = '0;
						sum_d = '0;
						if (sum_q != b) begin
							fail = 1'b1;
						end else begin
							phase_d = PH_FOOT;
						end
					end
				end
				PH_FOOT: begin
					phase_d = PH_HUNT;
					if (b != footer_q) begin
						fail = 1'b1;
					end else begin
						fail_d           = '0;
						cmd_push.valid   = 1'b1;
						cmd_push.cmd     = '{give_up: 1'b0, bank: bank_q};
						busy_set[bank_q] = 1'b1;
						bank_d           = ~bank_q;
					end
				end
				default: begin
					phase_d = PH_HUNT;
					if (b == header_q) begin
						phase_d = PH_BODY;
						cnt_d   = '0;
						sum_d   = '0;
					end else begin
						fail = 1'b1;
					end
				end
			endcase

			if (fail) begin
				phase_d = PH_HUNT;
				if (fail_inc >= retry_q) begin
					fail_d         = '0;
					cmd_push.valid = 1'b1;
					cmd_push.cmd   = '{give_up: 1'b1, bank: bank_q};
				end else begin
					fail_d = fail_inc;
				end
			end
		end
	end

	assign busy_clr = done.valid ? (2'b01 << done.bank) : 2'b00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= 8'hFF;
			footer_q  <= 8'hFE;
			timeout_q <= 16'd100;
			retry_q   <= 8'd3;
			phase_q   <= PH_HUNT;
			cnt_q     <= '0;
			sum_q     <= '0;
			fail_q    <= '0;
			idle_q    <= '0;
			bank_q    <= 1'b0;
			busy_q    <= 2'b00;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_HEADER:  header_q  <= cfg_wdata[BYTE_W-1:0];
					CFG_FOOTER:  footer_q  <= cfg_wdata[BYTE_W-1:0];
					CFG_TIMEOUT: timeout_q <= cfg_wdata[TICK_W-1:0];
					CFG_RETRY:   retry_q   <= cfg_wdata[BYTE_W-1:0];
					default:     header_q  <= header_q;
				endcase
			end
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			fail_q  <= fail_d;
			idle_q  <= idle_d;
			bank_q  <= bank_d;
			busy_q  <= (busy_q & ~busy_clr) | busy_set;
		end
	end

endmodule

@@ rtl/sfr_back.sv @@
// Back end: two-bank payload store, result sequencer and the output register.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sfr_pkg::store_wr_t         store_wr,
	input  logic                       fifo_empty,
	input  sfr_pkg::cmd_t              head,
	output logic                       fifo_rd,
	output sfr_pkg::done_t             done,
	input  logic                       pop,
	output logic                       empty,
	output logic                       status,
	output logic [sfr_pkg::IDX_W-1:0]  data_index,
	output logic [sfr_pkg::BYTE_W-1:0] data_byte,
	output logic                       last
);
	import sfr_pkg::*;

	logic [BYTE_W-1:0] store_q [2][DATA_LEN];

	logic              active_q;
	logic              give_up_q;
	logic              bank_q;
	logic [CNT_W-1:0]  idx_q;
	logic              out_valid_q;
	logic              status_q;
	logic [IDX_W-1:0]  index_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;

	logic              take;
	logic              load;
	logic              final_item;

	assign take       = pop && out_valid_q;
	assign load       = active_q && (!out_valid_q || take);
	assign final_item = give_up_q || (idx_q == CNT_W'(PAY_LEN - 1));
	assign fifo_rd    = !active_q && !fifo_empty;
	assign done.valid = load && final_item && !give_up_q;
	assign done.bank  = bank_q;

	assign empty      = !out_valid_q;
	assign status     = status_q;
	assign data_index = index_q;
	assign data_byte  = byte_q;
	assign last       = last_q;

	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			store_q[store_wr.bank][store_wr.addr] <= store_wr.data;
		end
		if (load) begin
			if (give_up_q) begin
				status_q <= ST_GIVE_UP;
				index_q  <= '0;
				byte_q   <= '0;
				last_q   <= 1'b1;
			end else begin
				status_q <= ST_DATA;
				index_q  <= IDX_W'(idx_q);
				byte_q   <= store_q[bank_q][idx_q];
				last_q   <= final_item;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			give_up_q   <= 1'b0;
			bank_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
			if (fifo_rd) begin
				active_q  <= 1'b1;
				give_up_q <= head.give_up;
				bank_q    <= head.bank;
				idx_q     <= '0;
			end else if (load) begin
				if (final_item) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/serial_frame_receiver.sv @@
// Top level of the serial frame receiver: front parser, command queue and result streamer.
// Depends on sfr_pkg, sfr_front, sfr_cmd_fifo and sfr_back.
`timescale 1ns / 1ps

// Usage
// Input channel: drive action (0 = byte received on rx_byte, 1 = one millisecond tick)
// with push high; the transaction completes on a rising edge where full is low.
// Result channel: while empty is low, status, data_index, data_byte and last show the
// oldest result; raise pop to take it. A good frame gives DATA_LEN-1 payload results,
// the final one marked by last. A give-up after retry_limit failures gives one result
// with status set, zero index and data, and last set.
// Configuration: cfg_we with cfg_index (0 header, 1 footer, 2 timeout, 3 retry limit)
// and cfg_wdata writes a register on that edge; write only while the block is idle.
// Throughput: one input transaction per cycle while full is low. A good frame
// occupies the result sequencer while it fetches the command and then loads one
// result per cycle while the receiver keeps taking them; the sequencer fetches the next
// command only after the final result of the current one is loaded.
// A result is registered after its command passes through the queue and the sequencer.
// Stalls: the payload store has two banks. If the receiver holds off pop, the parser keeps
// taking bytes into the other bank; full rises once that bank also holds a finished frame,
// or when the two-entry command queue fills.
// Reset: arst_n clears parser state, failure count, queue and output; registers return to
// header 0xFF, footer 0xFE, timeout 100, retry limit 3. No clearing pass is needed.
module serial_frame_receiver (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sfr_pkg::CFG_AW-1:0] cfg_index,
	input  logic [sfr_pkg::CFG_DW-1:0] cfg_wdata,
	input  logic                       push,
	output logic                       full,
	input  logic                       action,
	input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
	output logic                       empty,
	input  logic                       pop,
	output logic                       status,
	output logic [sfr_pkg::IDX_W-1:0]  data_index,
	output logic [sfr_pkg::BYTE_W-1:0] data_byte,
	output logic                       last
);
	import sfr_pkg::*;

	push_t     cmd_push;
	store_wr_t store_wr;
	done_t     done;
	cmd_t      head;
	logic      fifo_full;
	logic      fifo_empty;
	logic      fifo_rd;

	// The front classifies each transaction and queues work for the back.
	sfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.action    (action),
		.rx_byte   (rx_byte),
		.fifo_full (fifo_full),
		.done      (done),
		.full      (full),
		.cmd_push  (cmd_push),
		.store_wr  (store_wr)
	);

	// The command queue lets the parser run ahead of a stalled result channel.
	sfr_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_in    (cmd_push),
		.rd         (fifo_rd),
		.fifo_full  (fifo_full),
		.fifo_empty (fifo_empty),
		.head       (head)
	);

	// The back streams stored payload or a give-up result into the output register.
	sfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.store_wr   (store_wr),
		.fifo_empty (fifo_empty),
		.head       (head),
		.fifo_rd    (fifo_rd),
		.done       (done),
		.pop        (pop),
		.empty      (empty),
		.status     (status),
		.data_index (data_index),
		.data_byte  (data_byte),
		.last       (last)
	);

`ifndef SYNTH
	// The front must never issue a command that the queue cannot hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push.valid |-> !fifo_full)
		else $error("command pushed into a full queue");

	// A give-up result always carries zero index and data and closes its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_GIVE_UP) |-> (last && data_index == '0 && data_byte == '0))
		else $error("malformed give-up result");

	// A payload result is marked last exactly at the final payload position.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_DATA) |-> (last == (data_index == IDX_W'(PAY_LEN - 1))))
		else $error("last flag misplaced in payload stream");

	// The payload store is never written in the bank being streamed out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(store_wr.en && done.valid) |-> (store_wr.bank != done.bank))
		else $error("payload bank overwritten while streaming");
`endif

endmodule

@@ sim/sfr_frame_checker.sv @@
// Scoreboard for the serial frame receiver: watches the register, input and result ports,
// predicts the results of every accepted transaction and compares them field by field.
// Depends on sfr_pkg for widths, register codes and status codes.
`timescale 1ns / 1ps

module sfr_frame_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sfr_pkg::CFG_AW-1:0] cfg_index,
	input  logic [sfr_pkg::CFG_DW-1:0] cfg_wdata,
	input  logic                       push,
	input  logic                       full,
	input  logic                       action,
	input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
	input  logic                       empty,
	input  logic                       pop,
	input  logic                       status,
	input  logic [sfr_pkg::IDX_W-1:0]  data_index,
	input  logic [sfr_pkg::BYTE_W-1:0] data_byte,
	input  logic                       last,
	output int                         mismatch_count,
	output int                         results_owed,
	output int                         frames_done,
	output int                         give_ups_seen
);
	import sfr_pkg::*;

	localparam logic              ACT_BYTE   = 1'b0;
	localparam logic [BYTE_W-1:0] SUBST_BYTE = 8'h00;

	typedef enum logic [1:0] {
		SEEK_HEADER,
		TAKE_BODY,
		WAIT_FOOTER
	} rx_phase_t;

	typedef struct packed {
		logic              status;
		logic [IDX_W-1:0]  index;
		logic [BYTE_W-1:0] value;
		logic              last;
	} frame_result_t;

	logic [BYTE_W-1:0] header_val;
	logic [BYTE_W-1:0] footer_val;
	logic [TICK_W-1:0] timeout_val;
	logic [BYTE_W-1:0] retry_val;

	rx_phase_t         rx_phase;
	logic [CNT_W-1:0]  body_count;
	logic [BYTE_W-1:0] body_sum;
	logic [BYTE_W-1:0] body_store [PAY_LEN];
	logic [BYTE_W-1:0] fail_run;
	logic [TICK_W-1:0] quiet_ticks;

	frame_result_t owed_q [$];
	frame_result_t seen;
	frame_result_t want;

	function automatic frame_result_t make_result(input logic st, input int idx,
			input logic [BYTE_W-1:0] val, input logic lst);
		frame_result_t r;
		r.status = st;
		r.index  = idx[IDX_W-1:0];
		r.value  = val;
		r.last   = lst;
		return r;
	endfunction

	// A failure sends the parser back to hunting; enough of them in a row give up.
	task automatic charge_failure();
		rx_phase = SEEK_HEADER;
		fail_run = fail_run + 1'b1;
		if (fail_run >= retry_val) begin
			fail_run = '0;
			owed_q.push_back(make_result(ST_GIVE_UP, 0, '0, 1'b1));
			give_ups_seen++;
		end
	endtask

	task automatic absorb_byte(input logic [BYTE_W-1:0] b);
		logic sum_ok;
		int   k;
		case (rx_phase)
			TAKE_BODY: begin
				if (body_count < PAY_LEN) begin
					body_store[body_count] = b;
					body_sum   = body_sum + b;
					body_count = body_count + 1'b1;
				end else begin
					sum_ok     = (body_sum == b);
					body_count = '0;
					body_sum   = '0;
					if (!sum_ok) begin
						charge_failure();
					end else begin
						rx_phase = WAIT_FOOTER;
					end
				end
			end
			WAIT_FOOTER: begin
				rx_phase = SEEK_HEADER;
				if (b != footer_val) begin
					charge_failure();
				end else begin
					fail_run = '0;
					for (k = 0; k < PAY_LEN; k++) begin
						owed_q.push_back(make_result(ST_DATA, k, body_store[k],
							k == PAY_LEN - 1));
					end
					frames_done++;
				end
			end
			default: begin
				rx_phase = SEEK_HEADER;
				if (b == header_val) begin
					rx_phase   = TAKE_BODY;
					body_count = '0;
					body_sum   = '0;
				end else begin
					charge_failure();
				end
			end
		endcase
	endtask

	task automatic apply_transaction(input logic act, input logic [BYTE_W-1:0] b);
		if (act == ACT_BYTE) begin
			quiet_ticks = '0;
			absorb_byte(b);
		end else if (quiet_ticks >= timeout_val) begin
			quiet_ticks = '0;
			absorb_byte(SUBST_BYTE);
		end else begin
			quiet_ticks = quiet_ticks + 1'b1;
		end
	endtask

	task automatic check_field(input string field, input logic [BYTE_W-1:0] want_v,
			input logic [BYTE_W-1:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want_v,
				got_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_val     = 8'hFF;
			footer_val     = 8'hFE;
			timeout_val    = 16'd100;
			retry_val      = 8'd3;
			rx_phase       = SEEK_HEADER;
			body_count     = '0;
			body_sum       = '0;
			fail_run       = '0;
			quiet_ticks    = '0;
			mismatch_count = 0;
			frames_done    = 0;
			give_ups_seen  = 0;
			owed_q.delete();
			results_owed <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_HEADER:  header_val  = cfg_wdata[BYTE_W-1:0];
					CFG_FOOTER:  footer_val  = cfg_wdata[BYTE_W-1:0];
					CFG_TIMEOUT: timeout_val = cfg_wdata[TICK_W-1:0];
					CFG_RETRY:   retry_val   = cfg_wdata[BYTE_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				seen = make_result(status, data_index, data_byte, last);
				if (owed_q.size() == 0) begin
					$display("%0t: result with nothing expected, got status %0d index %0d",
						$time, seen.status, seen.index);
					$display("%0t:   byte 0x%0h last %0d", $time, seen.value, seen.last);
					mismatch_count++;
				end else begin
					want = owed_q.pop_front();
					check_field("status", want.status, seen.status);
					check_field("data_index", want.index, seen.index);
					check_field("data_byte", want.value, seen.value);
					check_field("last", want.last, seen.last);
				end
			end
			if (push && !full) begin
				apply_transaction(action, rx_byte);
			end
			results_owed <= owed_q.size();
		end
	end

endmodule

@@ sim/tb_serial_frame_receiver.sv @@
// Testbench top for the serial frame receiver: clock, reset, register setup, input and result
// traffic, watchdog and verdict. Depends on sfr_pkg, serial_frame_receiver and sfr_frame_checker.
`timescale 1ns / 1ps

module tb_serial_frame_receiver;
	import sfr_pkg::*;

	// Codes of the action input.
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// After the last result has arrived, a frame can still be on its way through the
	// parser and the command queue; this many quiet cycles cover it with margin.
	localparam int SETTLE_CYCLES  = 2 * DATA_LEN + 4;
	// Length of the long pop hold-off that fills the block up.
	localparam int HOLD_CYCLES    = 400;
	// Cycles without any accepted transaction before the run is declared hung. The worst
	// correct case is the hold-off above plus a long random stall, far below this.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 30;

	// Payload of the directed good frame: zero, all ones, both single-bit extremes and so on.
	localparam logic [8*PAY_LEN-1:0] DIRECTED_BODY = 56'hAA_55_01_7F_80_FF_00;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_SUM,
		FRAME_BAD_FOOTER
	} frame_kind_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_AW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_wdata;
	logic                push;
	logic                full;
	logic                action;
	logic [BYTE_W-1:0]   rx_byte;
	logic                empty;
	logic                pop;
	logic                status;
	logic [IDX_W-1:0]    data_index;
	logic [BYTE_W-1:0]   data_byte;
	logic                last;

	int mismatch_count;
	int results_owed;
	int frames_done;
	int give_ups_seen;

	// Traffic shaping, changed by the stimulus between phases.
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;

	int items_sent;
	int quiet_cycles = 0;

	// Copies of the register values, so that frames can be built to match them.
	logic [BYTE_W-1:0] cur_header;
	logic [BYTE_W-1:0] cur_footer;
	logic [TICK_W-1:0] cur_timeout;
	logic [BYTE_W-1:0] frame_body [PAY_LEN];

	serial_frame_receiver dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.push       (push),
		.full       (full),
		.action     (action),
		.rx_byte    (rx_byte),
		.empty      (empty),
		.pop        (pop),
		.status     (status),
		.data_index (data_index),
		.data_byte  (data_byte),
		.last       (last)
	);

	sfr_frame_checker frame_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.push           (push),
		.full           (full),
		.action         (action),
		.rx_byte        (rx_byte),
		.empty          (empty),
		.pop            (pop),
		.status         (status),
		.data_index     (data_index),
		.data_byte      (data_byte),
		.last           (last),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed),
		.frames_done    (frames_done),
		.give_ups_seen  (give_ups_seen)
	);

	// 10 ns clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Count cycles in which no transaction of any kind completes. Register writes count as
	// activity so that a burst of them never looks like a hang.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// Result side. Each cycle pop is raised or not at random according to the stall rate.
	// When the stimulus asks for a hold-off, pop stays low for a long counted stretch while
	// the sender keeps pushing, so both payload banks fill and full
	// must hold the sender back.
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one input transaction, after a random number of idle cycles, and return right
	// after the edge that accepts it. Push is left high so that a following call can keep
	// it high without a gap; whoever stops sending lowers it.
	task automatic send_item(input logic act, input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		action  <= act;
		rx_byte <= b;
		do @(posedge clk); while (full);
		items_sent++;
	endtask

	// A zero byte may instead arrive as a timeout: when the timeout is short, half of the
	// zero bytes are replaced by enough ticks to make the block substitute one.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (b == 8'h00 && cur_timeout < 4 && $urandom_range(1) == 1) begin
			repeat (cur_timeout + 1) send_item(ACT_TICK, BYTE_W'($urandom));
		end else begin
			send_item(ACT_BYTE, b);
		end
	endtask

	// Send header, the payload in frame_body, checksum and footer. A bad checksum ends the
	// frame there, since the block goes back to hunting and would not take a footer.
	task automatic send_frame(input frame_kind_t kind);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] flip;
		int                k;
		sum = '0;
		send_byte(cur_header);
		for (k = 0; k < PAY_LEN; k++) begin
			send_byte(frame_body[k]);
			sum = sum + frame_body[k];
		end
		if (kind == FRAME_BAD_SUM) begin
			flip = BYTE_W'($urandom_range(1, 255));
			send_byte(sum ^ flip);
		end else begin
			send_byte(sum);
			if (kind == FRAME_BAD_FOOTER) begin
				flip = 8'h01 << $urandom_range(7);
				send_byte(cur_footer ^ flip);
			end else begin
				send_byte(cur_footer);
			end
		end
	endtask

	// Random payload with zeros and all-ones bytes more common than chance would make them.
	task automatic fill_random_body();
		int k;
		for (k = 0; k < PAY_LEN; k++) begin
			case ($urandom_range(7))
				0: frame_body[k] = 8'h00;
				1: frame_body[k] = 8'hFF;
				default: frame_body[k] = BYTE_W'($urandom);
			endcase
		end
	endtask

	// Stop sending and wait until every predicted result has been taken, then let the block
	// settle. Register writes are only made after this.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges.
	task automatic set_config(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] ftr,
			input logic [TICK_W-1:0] tmo, input logic [BYTE_W-1:0] lim);
		cur_header  = hdr;
		cur_footer  = ftr;
		cur_timeout = tmo;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_HEADER;
		cfg_wdata <= {8'h00, hdr};
		@(posedge clk);
		cfg_index <= CFG_FOOTER;
		cfg_wdata <= {8'h00, ftr};
		@(posedge clk);
		cfg_index <= CFG_TIMEOUT;
		cfg_wdata <= tmo;
		@(posedge clk);
		cfg_index <= CFG_RETRY;
		cfg_wdata <= {8'h00, lim};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed frames with random content, so that the parser gets through to the
	// checksum and footer checks; the rest is broken frames, stray bytes and tick runs.
	task automatic run_phase(input int n_items);
		int first;
		int pick;
		first = items_sent;
		while (items_sent - first < n_items) begin
			pick = $urandom_range(99);
			fill_random_body();
			if (pick < 60) begin
				send_frame(FRAME_GOOD);
			end else if (pick < 70) begin
				send_frame(FRAME_BAD_SUM);
			end else if (pick < 80) begin
				send_frame(FRAME_BAD_FOOTER);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
			end else begin
				repeat ($urandom_range(1, 6)) send_item(ACT_TICK, BYTE_W'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		logic [BYTE_W-1:0] sum;
		int                k;
		int                phase_no;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_HEADER;
		cfg_wdata <= '0;
		push      <= 1'b0;
		action    <= ACT_BYTE;
		rx_byte   <= '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		items_sent     = 0;
		cur_header     = 8'hFF;
		cur_footer     = 8'hFE;
		cur_timeout    = 16'd100;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first with the reset register values: one good frame whose payload
		// holds the byte extremes, then three non-header bytes in a row, which reach the
		// default retry limit and give up.
		for (k = 0; k < PAY_LEN; k++) begin
			frame_body[k] = DIRECTED_BODY[8*k +: 8];
		end
		send_frame(FRAME_GOOD);
		send_item(ACT_BYTE, 8'h12);
		send_item(ACT_BYTE, 8'h00);
		send_item(ACT_BYTE, 8'hFE);
		drain();

		// Header zero, zero timeout, retry limit one. The first tick substitutes a zero byte,
		// which opens a frame. Its checksum is wrong, so the block gives up at once, and the
		// footer byte that follows is taken as a non-header byte while hunting.
		set_config(8'h00, 8'hFF, 16'd0, 8'd1);
		send_item(ACT_TICK, 8'hFF);
		sum = '0;
		for (k = 0; k < PAY_LEN; k++) begin
			send_item(ACT_BYTE, frame_body[k]);
			sum = sum + frame_body[k];
		end
		send_item(ACT_BYTE, sum ^ 8'h01);
		send_item(ACT_BYTE, 8'hFF);
		drain();

		// Largest timeout, so ticks only count up; a retry limit of zero gives up on the
		// very first failure.
		set_config(8'hFF, 8'h00, 16'hFFFF, 8'd0);
		repeat (3) send_item(ACT_TICK, 8'h00);
		send_item(ACT_BYTE, 8'h01);

		// Random part: one phase per idling pattern, each with its own register setting.
		for (phase_no = 0; phase_no < 4; phase_no++) begin
			drain();
			case (phase_no)
				0: begin
					set_config(BYTE_W'($urandom), BYTE_W'($urandom),
						TICK_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(1, 4)));
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					set_config(8'h00, 8'hFF, 16'd0, 8'd2);
					send_idle_pct  = 80;
					recv_stall_pct = 0;
				end
				2: begin
					set_config(8'hFF, 8'h00, 16'hFFFF, 8'd255);
					send_idle_pct  = 0;
					recv_stall_pct = 80;
				end
				default: begin
					set_config(BYTE_W'($urandom), BYTE_W'($urandom),
						TICK_W'($urandom_range(1, 3)), 8'd1);
					send_idle_pct  = 20;
					recv_stall_pct = 20;
				end
			endcase
			run_phase(PHASE_ITEMS);
		end

		// Back-pressure: the result side holds off for a long stretch while good frames keep
		// coming at full rate, so the block has to fill up and raise full.
		drain();
		set_config(BYTE_W'($urandom), BYTE_W'($urandom), 16'd100, 8'd3);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		repeat (6) begin
			fill_random_body();
			send_frame(FRAME_GOOD);
		end
		drain();

		$display("Run covered %0d input transactions: directed frames, four idling phases",
			items_sent);
		$display("and a full-block stall; %0d good frames and %0d give-ups were checked.",
			frames_done, give_ups_seen);
		if (mismatch_count == 0 && results_owed == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/sfr_pkg.sv
rtl/sfr_cmd_fifo.sv
rtl/sfr_front.sv
rtl/sfr_back.sv
rtl/serial_frame_receiver.sv
sim/sfr_frame_checker.sv
sim/tb_serial_frame_receiver.sv
